FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Every property is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MSFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MSFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/msfd_pkg.sv
// ----------------------------------------------------------------------------
// msfd_pkg
// Shared constants, types and helpers of the multi-server FIFO dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package msfd_pkg;

	localparam int MAX_SERVERS = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int TICK_W  = 32;
	localparam int ID_W    = 16;
	localparam int SVC_W   = 16;
	localparam int ACT_W   = 4;
	localparam int SRV_W   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int BUSY_W  = $clog2(MAX_SERVERS + 1);
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = TICK_W + SVC_W + ID_W;

	// one queued task
	typedef struct packed {
		logic [TICK_W-1:0] arrival;
		logic [SVC_W-1:0]  service;
		logic [ID_W-1:0]   id;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // beat taken on the input channel
		logic rd_en;     // read queue head
		logic load_out;  // run admission, load the output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic queue_empty;
	} dp_sts_t;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

FILE: sv/msfd_ram.sv
// ----------------------------------------------------------------------------
// msfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msfd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/msfd_ctrl.sv
// ----------------------------------------------------------------------------
// msfd_ctrl
// Sequencer: take tick, read queue head, admit and load the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msfd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire msfd_pkg::dp_sts_t   sts,
	output msfd_pkg::ctrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_ADMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a new beat
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = !sts.queue_empty;
				state_d   = ST_ADMIT;
			end
			ST_ADMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/msfd_dp.sv
// ----------------------------------------------------------------------------
// msfd_dp
// Datapath: tick counter, server countdowns, task queue, admission logic and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msfd_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire msfd_pkg::ctrl_cmd_t             cmd,
	output msfd_pkg::dp_sts_t                    sts,
	input  wire logic                            cfg_wr_en,
	input  wire logic [msfd_pkg::ACT_W-1:0]      cfg_wr_data,
	input  wire logic                            task_arrives,
	input  wire logic [msfd_pkg::SVC_W-1:0]      service_time,
	output logic                                 admitted,
	output logic      [msfd_pkg::SRV_W-1:0]      server_index,
	output logic      [msfd_pkg::ID_W-1:0]       task_id,
	output logic      [msfd_pkg::SVC_W-1:0]      task_service,
	output logic      [msfd_pkg::TICK_W-1:0]     waited_ticks,
	output logic                                 arrival_dropped,
	output logic      [msfd_pkg::FILL_W-1:0]     queued_count,
	output logic      [msfd_pkg::BUSY_W-1:0]     busy_count
);

	logic [msfd_pkg::TICK_W-1:0] tick_q;
	logic [msfd_pkg::TICK_W-1:0] tick_nxt;
	logic [msfd_pkg::ID_W-1:0]   next_id_q;
	logic [msfd_pkg::SVC_W-1:0]  remain_q [msfd_pkg::MAX_SERVERS];
	logic [msfd_pkg::QPTR_W-1:0] head_q;
	logic [msfd_pkg::QPTR_W-1:0] tail_q;
	logic [msfd_pkg::FILL_W-1:0] fill_q;
	logic [msfd_pkg::ACT_W-1:0]  active_q;
	logic                        dropped_q;

	logic                          q_full;
	logic                          push;
	msfd_pkg::entry_t              wr_entry;
	logic [msfd_pkg::ENTRY_W-1:0]  rd_raw;
	msfd_pkg::entry_t              rd_entry;

	logic                          found;
	logic                          admit;
	logic [msfd_pkg::SRV_W-1:0]    pick;
	logic [msfd_pkg::BUSY_W-1:0]   busy;
	logic                          nz;

	// output register
	logic                          admitted_q;
	logic [msfd_pkg::SRV_W-1:0]    server_index_q;
	logic [msfd_pkg::ID_W-1:0]     task_id_q;
	logic [msfd_pkg::SVC_W-1:0]    task_service_q;
	logic [msfd_pkg::TICK_W-1:0]   waited_ticks_q;
	logic                          arrival_dropped_q;
	logic [msfd_pkg::FILL_W-1:0]   queued_count_q;
	logic [msfd_pkg::BUSY_W-1:0]   busy_count_q;

	assign tick_nxt = tick_q + 1'b1;
	assign q_full   = (fill_q == msfd_pkg::FILL_W'(msfd_pkg::QUEUE_DEPTH));
	assign push     = cmd.accept && task_arrives && !q_full;

	assign wr_entry.arrival = tick_nxt;
	assign wr_entry.service = service_time;
	assign wr_entry.id      = next_id_q;

	msfd_ram #(
		.WIDTH (msfd_pkg::ENTRY_W),
		.DEPTH (msfd_pkg::QUEUE_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (tail_q),
		.wr_data (wr_entry),
		.rd_en   (cmd.rd_en),
		.rd_addr (head_q),
		.rd_data (rd_raw)
	);

	assign rd_entry        = msfd_pkg::entry_t'(rd_raw);
	assign sts.queue_empty = (fill_q == '0);

	// lowest free server in use; busy count after the admission
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = msfd_pkg::MAX_SERVERS - 1; i >= 0; i--) begin
			if (remain_q[i] == '0 && int'(active_q) > i) begin
				found = 1'b1;
				pick  = msfd_pkg::SRV_W'(i);
			end
		end
		admit = found && (fill_q != '0);

		busy = '0;
		nz   = 1'b0;
		for (int i = 0; i < msfd_pkg::MAX_SERVERS; i++) begin
			nz = (remain_q[i] != '0);
			if (admit && pick == msfd_pkg::SRV_W'(i)) begin
				nz = (rd_entry.service != '0);
			end
			busy = busy + msfd_pkg::BUSY_W'(nz);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			next_id_q <= msfd_pkg::ID_W'(1);
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			active_q  <= msfd_pkg::ACT_W'(1);
			for (int i = 0; i < msfd_pkg::MAX_SERVERS; i++) begin
				remain_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				tick_q <= tick_nxt;
				for (int i = 0; i < msfd_pkg::MAX_SERVERS; i++) begin
					if (remain_q[i] != '0) begin
						remain_q[i] <= remain_q[i] - 1'b1;
					end
				end
				if (task_arrives) begin
					next_id_q <= next_id_q + 1'b1;
				end
				if (push) begin
					tail_q <= msfd_pkg::ptr_inc(tail_q);
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.load_out && admit) begin
				head_q         <= msfd_pkg::ptr_inc(head_q);
				fill_q         <= fill_q - 1'b1;
				remain_q[pick] <= rd_entry.service;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dropped_q <= task_arrives && q_full;
		end
		if (cmd.load_out) begin
			admitted_q        <= admit;
			server_index_q    <= admit ? pick : '0;
			task_id_q         <= admit ? rd_entry.id : '0;
			task_service_q    <= admit ? rd_entry.service : '0;
			waited_ticks_q    <= admit ? (tick_q - rd_entry.arrival) : '0;
			arrival_dropped_q <= dropped_q;
			queued_count_q    <= admit ? (fill_q - 1'b1) : fill_q;
			busy_count_q      <= busy;
		end
	end

	assign admitted        = admitted_q;
	assign server_index    = server_index_q;
	assign task_id         = task_id_q;
	assign task_service    = task_service_q;
	assign waited_ticks    = waited_ticks_q;
	assign arrival_dropped = arrival_dropped_q;
	assign queued_count    = queued_count_q;
	assign busy_count      = busy_count_q;

endmodule

`default_nettype wire

FILE: sv/multi_server_fifo_dispatcher.sv
// A tick taken in the idle step passes through the read and admit steps before its
// result beat is loaded; no new tick is taken until the sequencer is back in idle, and
//   the queue RAM's registered read sits between the tick update and the admission step.
// A stalled output holds the sequencer in its admit step until the beat leaves.
// Reset (arst_n low, async): tick 0, next id 1, servers free, queue empty,
//   active_servers 1, no beat pending; queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
// multi_server_fifo_dispatcher
// Multi-server FIFO dispatcher: per tick, counts down busy servers, queues an
// arriving task and hands the oldest queued task to the lowest free server.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_server_fifo_dispatcher (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// config
	input  wire logic                            cfg_wr_en,
	input  wire logic [msfd_pkg::ACT_W-1:0]      cfg_wr_data,
	// tick input
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            task_arrives,
	input  wire logic [msfd_pkg::SVC_W-1:0]      service_time,
	// result output
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 admitted,
	output logic      [msfd_pkg::SRV_W-1:0]      server_index,
	output logic      [msfd_pkg::ID_W-1:0]       task_id,
	output logic      [msfd_pkg::SVC_W-1:0]      task_service,
	output logic      [msfd_pkg::TICK_W-1:0]     waited_ticks,
	output logic                                 arrival_dropped,
	output logic      [msfd_pkg::FILL_W-1:0]     queued_count,
	output logic      [msfd_pkg::BUSY_W-1:0]     busy_count
);

	// Sequencer steps per tick beat:
	//   idle  - take the beat; bump tick, count servers down, push arrival
	//   read  - fetch the queue head from RAM (skipped read when empty)
	//   admit - pick lowest free server in use, pop, load the output beat
	// The output register frees the sequencer to take the next beat while
	// the previous result beat is still stalled downstream.
	msfd_pkg::ctrl_cmd_t cmd;
	msfd_pkg::dp_sts_t   sts;

	msfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath holds all counters, the server countdown lanes, the queue
	// pointers and RAM, and the result register.
	msfd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.task_arrives    (task_arrives),
		.service_time    (service_time),
		.admitted        (admitted),
		.server_index    (server_index),
		.task_id         (task_id),
		.task_service    (task_service),
		.waited_ticks    (waited_ticks),
		.arrival_dropped (arrival_dropped),
		.queued_count    (queued_count),
		.busy_count      (busy_count)
	);

endmodule

`default_nettype wire

FILE: sv/msfd_checker.sv
// ----------------------------------------------------------------------------
// msfd_checker
// Port-level checks of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msfd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        admitted,
	input wire logic [msfd_pkg::SRV_W-1:0]  server_index,
	input wire logic [msfd_pkg::ID_W-1:0]   task_id,
	input wire logic [msfd_pkg::SVC_W-1:0]  task_service,
	input wire logic [msfd_pkg::TICK_W-1:0] waited_ticks,
	input wire logic                        arrival_dropped,
	input wire logic [msfd_pkg::FILL_W-1:0] queued_count,
	input wire logic [msfd_pkg::BUSY_W-1:0] busy_count
);

	// one tick in flight: stall right after a beat is taken
	`MSFD_ASSERT_NEXT(a_stall_after_take, in_valid && !in_stall, in_stall, "no stall after input beat")

	// a beat without admission reports zero task fields
	`MSFD_ASSERT_NOW(a_zero_when_idle, out_valid && !admitted, server_index == '0 && task_id == '0 && task_service == '0 && waited_ticks == '0, "nonzero fields without admission")

	// counts stay within capacity
	`MSFD_ASSERT_NOW(a_count_range, out_valid, queued_count <= msfd_pkg::FILL_W'(msfd_pkg::QUEUE_DEPTH) && busy_count <= msfd_pkg::BUSY_W'(msfd_pkg::MAX_SERVERS), "count out of range")

	// a drop means the queue was full; at most one pop follows
	`MSFD_ASSERT_NOW(a_drop_full, out_valid && arrival_dropped, queued_count >= msfd_pkg::FILL_W'(msfd_pkg::QUEUE_DEPTH - 1), "drop with queue not full")

	// stalled result beat holds
	`MSFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(task_id) && $stable(queued_count), "stalled beat changed")

endmodule

bind multi_server_fifo_dispatcher msfd_checker u_msfd_checker (.*);

`default_nettype wire

FILE: verif/msfd_dispatch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msfd_dispatch_checker
// Passive checker for the dispatcher. Tracks the active_servers register,
// predicts one dispatch result per accepted tick beat and compares every
// accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------

module msfd_dispatch_checker
	import msfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ACT_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              task_arrives,
	input  logic [SVC_W-1:0]  service_time,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              admitted,
	input  logic [SRV_W-1:0]  server_index,
	input  logic [ID_W-1:0]   task_id,
	input  logic [SVC_W-1:0]  task_service,
	input  logic [TICK_W-1:0] waited_ticks,
	input  logic              arrival_dropped,
	input  logic [FILL_W-1:0] queued_count,
	input  logic [BUSY_W-1:0] busy_count,
	output int                failures,
	output int                pending
);

	typedef struct packed {
		logic              admitted;
		logic [SRV_W-1:0]  server;
		logic [ID_W-1:0]   id;
		logic [SVC_W-1:0]  service;
		logic [TICK_W-1:0] waited;
		logic              dropped;
		logic [FILL_W-1:0] queued;
		logic [BUSY_W-1:0] busy;
	} dispatch_t;

	// shadow of the block's state
	logic [TICK_W-1:0] tick_now;
	logic [ID_W-1:0]   id_next;
	logic [SVC_W-1:0]  svc_left [MAX_SERVERS];
	entry_t            waiting [$];
	logic [ACT_W-1:0]  servers_on;

	dispatch_t owed_dispatches [$];
	dispatch_t want;

	function automatic dispatch_t dispatch_tick(input logic arrives,
			input logic [SVC_W-1:0] svc);
		dispatch_t r;
		entry_t    e;
		int        used;
		int        busy;
		int        i;
		logic      taken;
		r = '0;
		taken = 1'b0;
		busy = 0;
		tick_now = tick_now + 1'b1;
		for (i = 0; i < MAX_SERVERS; i++)
			if (svc_left[i] != '0)
				svc_left[i] = svc_left[i] - 1'b1;
		// arrival is queued before admission; a full queue still burns an id
		if (arrives) begin
			if (waiting.size() < QUEUE_DEPTH) begin
				e.id = id_next;
				e.service = svc;
				e.arrival = tick_now;
				waiting.push_back(e);
			end else begin
				r.dropped = 1'b1;
			end
			id_next = id_next + 1'b1;
		end
		used = (servers_on > MAX_SERVERS) ? MAX_SERVERS : servers_on;
		if (waiting.size() != 0) begin
			for (i = 0; i < used; i++) begin
				if (!taken && svc_left[i] == '0) begin
					e = waiting.pop_front();
					taken = 1'b1;
					r.admitted = 1'b1;
					r.server = SRV_W'(i);
					r.id = e.id;
					r.service = e.service;
					r.waited = tick_now - e.arrival;
					svc_left[i] = e.service;
				end
			end
		end
		for (i = 0; i < MAX_SERVERS; i++)
			if (svc_left[i] != '0)
				busy++;
		r.queued = FILL_W'(waiting.size());
		r.busy = BUSY_W'(busy);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [TICK_W-1:0] exp_v,
			input logic [TICK_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now = '0;
			id_next = ID_W'(1);
			for (int k = 0; k < MAX_SERVERS; k++)
				svc_left[k] = '0;
			waiting.delete();
			owed_dispatches.delete();
			servers_on = ACT_W'(1);
			failures = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				servers_on = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (owed_dispatches.size() == 0) begin
					$error("result beat with no prediction waiting");
					failures++;
				end else begin
					want = owed_dispatches.pop_front();
					check_field("admitted", want.admitted, admitted);
					check_field("server_index", want.server, server_index);
					check_field("task_id", want.id, task_id);
					check_field("task_service", want.service, task_service);
					check_field("waited_ticks", want.waited, waited_ticks);
					check_field("arrival_dropped", want.dropped, arrival_dropped);
					check_field("queued_count", want.queued, queued_count);
					check_field("busy_count", want.busy, busy_count);
				end
			end
			if (in_valid && !in_stall)
				owed_dispatches.push_back(dispatch_tick(task_arrives, service_time));
			pending = owed_dispatches.size();
		end
	end

endmodule

FILE: verif/multi_server_fifo_dispatcher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_server_fifo_dispatcher_test
// Drives tick beats and active_servers settings into the dispatcher, with
// random idling on both channels; the checker beside the block predicts and
// compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------

module multi_server_fifo_dispatcher_test;
	import msfd_pkg::*;

	// cycles with no beat on either channel before the run is called hung
	localparam int HANG_LIMIT = 2000;
	// settle time before a register write, and tail at the end
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 10;
	localparam int PHASES = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [ACT_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              task_arrives = 1'b0;
	logic [SVC_W-1:0]  service_time = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              admitted;
	logic [SRV_W-1:0]  server_index;
	logic [ID_W-1:0]   task_id;
	logic [SVC_W-1:0]  task_service;
	logic [TICK_W-1:0] waited_ticks;
	logic              arrival_dropped;
	logic [FILL_W-1:0] queued_count;
	logic [BUSY_W-1:0] busy_count;

	int   failures;
	int   pending;
	int   quiet_cycles = 0;
	// random idling on both sides while set
	logic jitter = 1'b1;

	// register settings per random phase: saturating, single server, full
	// width, none at all (queue fills and drops), and a few others
	logic [ACT_W-1:0] phase_setting [PHASES] = '{
		4'd15, 4'd1, 4'd8, 4'd0, 4'd3, 4'd9, 4'd5, 4'd2, 4'd8, 4'd4
	};

	multi_server_fifo_dispatcher dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.task_arrives    (task_arrives),
		.service_time    (service_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.admitted        (admitted),
		.server_index    (server_index),
		.task_id         (task_id),
		.task_service    (task_service),
		.waited_ticks    (waited_ticks),
		.arrival_dropped (arrival_dropped),
		.queued_count    (queued_count),
		.busy_count      (busy_count)
	);

	msfd_dispatch_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.task_arrives    (task_arrives),
		.service_time    (service_time),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.admitted        (admitted),
		.server_index    (server_index),
		.task_id         (task_id),
		.task_service    (task_service),
		.waited_ticks    (waited_ticks),
		.arrival_dropped (arrival_dropped),
		.queued_count    (queued_count),
		.busy_count      (busy_count),
		.failures        (failures),
		.pending         (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver side: stall about 29% of cycles unless jitter is off
	always @(posedge clk) begin
		out_stall <= jitter && ($urandom_range(99) < 29);
	end

	// hang detector: any beat on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One tick beat. Random idle cycles go in front; valid and payload then
	// hold until the beat is taken.
	task automatic send_tick(input logic arrives, input logic [SVC_W-1:0] svc);
		while (jitter && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		task_arrives <= arrives;
		service_time <= svc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Register write only once every predicted result has come out.
	task automatic write_active(input logic [ACT_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random ticks: arrival density and service spread are per phase, so some
	// phases fill the queue to drops and others drain it. Zero service and
	// the odd full-width service (long-lived server) are mixed in.
	task automatic run_phase(input int count, input int arrive_pct, input int svc_cap);
		logic             arr;
		logic [SVC_W-1:0] svc;
		int               pick;
		for (int n = 0; n < count; n++) begin
			arr = ($urandom_range(99) < arrive_pct);
			pick = $urandom_range(99);
			if (pick < 20)
				svc = '0;
			else if (pick < 99)
				svc = SVC_W'($urandom_range(svc_cap));
			else
				svc = SVC_W'($urandom);
			send_tick(arr, svc);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two servers: idle tick, zero service (server stays free), the
		// full-width service parking server 1, then a server freed and
		// refilled on the same tick
		write_active(ACT_W'(2));
		send_tick(1'b0, '0);
		send_tick(1'b1, '0);
		send_tick(1'b1, SVC_W'(3));
		send_tick(1'b1, '1);
		send_tick(1'b1, SVC_W'(2));
		send_tick(1'b0, SVC_W'(16'h5a5a));
		send_tick(1'b1, SVC_W'(1));
		send_tick(1'b1, SVC_W'(1));

		// no servers: nothing admitted, queue fills, the last arrivals drop
		write_active(ACT_W'(0));
		for (int n = 0; n < 17; n++)
			send_tick(1'b1, SVC_W'(1 + n % 4));

		for (int p = 0; p < PHASES; p++) begin
			write_active(phase_setting[p]);
			// one phase runs with both sides at full rate
			jitter <= (p != 4);
			run_phase((phase_setting[p] == 0) ? 25 : 58, $urandom_range(30, 95),
				4 * phase_setting[p] + 2);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
